// File: sv/whtdp_pkg.sv
// Shared types and constants for the double-probe word hash table.
package whtdp_pkg;
  localparam int TABLE_SIZE = 569;
  localparam int WORD_MAX   = 20;
  localparam int SLOT_W     = $clog2(TABLE_SIZE);
  localparam int LEN_W      = $clog2(WORD_MAX + 1);
  localparam int POS_W      = $clog2(WORD_MAX);
  localparam int CNT_W      = $clog2(TABLE_SIZE + 1);
  localparam int LTR_W      = 5;
  localparam int ADDR_W     = $clog2(TABLE_SIZE * WORD_MAX);
  // unreduced word hash: sum of letter*26*pos over a whole word
  localparam int HASH_W     = $clog2(31 * 26 * WORD_MAX * (WORD_MAX - 1) / 2 + 1);
  // reciprocal reduction mod TABLE_SIZE, exact for inputs below 2**MOD_W
  localparam int MOD_W      = $clog2(TABLE_SIZE * TABLE_SIZE);
  localparam int MOD_K      = MOD_W + SLOT_W;
  localparam int MOD_M_W    = MOD_K - SLOT_W + 1;
  localparam int MOD_M      = ((1 << MOD_K) + TABLE_SIZE - 1) / TABLE_SIZE;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_FOUND     = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_TOO_LONG  = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_READ, S_CHECK, S_CMP, S_STEP, S_WRITE, S_DONE
  } state_t;

  typedef struct packed {
    logic clear;       // write length zero at clear address
    logic clr_adv;
    logic letter_in;   // accept letter into buffer
    logic start_walk;
    logic read_len;    // length read at key (never set; the length memory reads at key every cycle)
    logic cmp_start;
    logic cmp_adv;
    logic step;
    logic write_adv;
    logic word_reset;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic len_empty;
    logic len_eq;
    logic cmp_done;
    logic cmp_ok;
    logic walk_end;
    logic write_done;
    logic too_long;
  } sts_t;
endpackage

// File: sv/whtdp_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
module whtdp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: sv/whtdp_datapath.sv
// Word buffer, hash, probe walk and table memories.
module whtdp_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  whtdp_pkg::cmd_t        cmd,
  input  logic [4:0]             letter,
  output whtdp_pkg::sts_t        sts,
  output logic [9:0]             slot_out,
  output logic [9:0]             probes_out
);
  import whtdp_pkg::*;

  logic [LEN_W-1:0]  word_length;
  logic [HASH_W-1:0] hash_sum;
  logic              too_long;
  logic [LTR_W-1:0]  word_buffer [WORD_MAX];
  logic [SLOT_W-1:0] key, start;
  logic [CNT_W-1:0]  probes, j;
  logic [SLOT_W-1:0] clr_addr;
  logic [POS_W-1:0]  idx;
  logic              mismatch;

  // x mod TABLE_SIZE by reciprocal multiplication
  function automatic logic [SLOT_W-1:0] mod_table(input logic [MOD_W-1:0] x);
    logic [MOD_W+MOD_M_W-1:0] p;
    logic [SLOT_W-1:0]        q;
    p = (MOD_W + MOD_M_W)'(x) * (MOD_W + MOD_M_W)'(MOD_M);
    q = SLOT_W'(p >> MOD_K);
    return SLOT_W'(x - MOD_W'(q * TABLE_SIZE));
  endfunction

  // hash: sum kept unreduced per letter, reduced once when the walk starts
  logic [LTR_W+LEN_W+4:0] prod;
  logic [SLOT_W-1:0]      hash_mod;
  assign prod = (LTR_W + LEN_W + 5)'(letter) * (LTR_W + LEN_W + 5)'(26) *
                (LTR_W + LEN_W + 5)'(word_length);
  assign hash_mod = mod_table(MOD_W'(hash_sum));

  // next probe: key + j*(1 + key mod (N-1)) mod N
  // product registered while the slot is read, reduction while it is checked
  logic [SLOT_W-1:0] kmod;
  logic [SLOT_W:0]   inc;
  logic [MOD_W-1:0]  step_prod;
  logic [SLOT_W-1:0] key_next;
  logic [CNT_W-1:0]  j1;
  assign kmod = (key >= SLOT_W'(TABLE_SIZE - 1)) ? SLOT_W'(key - SLOT_W'(TABLE_SIZE - 1)) : key;
  assign inc  = (SLOT_W + 1)'(kmod) + 1'b1;
  assign j1   = j + 1'b1;

  always_ff @(posedge clk) begin
    step_prod <= MOD_W'(j1) * MOD_W'(inc);
    key_next  <= mod_table(MOD_W'(key) + step_prod);
  end

  // memories
  logic              len_we;
  logic [SLOT_W-1:0] len_wa;
  logic [LEN_W-1:0]  len_wd, len_rd;
  logic              ltr_we;
  logic [ADDR_W-1:0] ltr_wa, ltr_ra;
  logic [LTR_W-1:0]  ltr_rd;

  assign len_we = cmd.clear || (cmd.write_adv && idx == '0);
  assign len_wa = cmd.clear ? clr_addr : key;
  assign len_wd = cmd.clear ? '0 : word_length;
  assign ltr_we = cmd.write_adv;
  assign ltr_wa = ADDR_W'(key * WORD_MAX) + ADDR_W'(idx);
  assign ltr_ra = ADDR_W'(key * WORD_MAX) + ADDR_W'(idx);

  whtdp_ram #(.WIDTH(LEN_W), .DEPTH(TABLE_SIZE)) u_len (
    .clk, .we(len_we), .waddr(len_wa), .wdata(len_wd), .raddr(key), .rdata(len_rd));
  whtdp_ram #(.WIDTH(LTR_W), .DEPTH(TABLE_SIZE * WORD_MAX)) u_ltr (
    .clk, .we(ltr_we), .waddr(ltr_wa), .wdata(word_buffer[idx]), .raddr(ltr_ra),
    .rdata(ltr_rd));

  logic [POS_W-1:0] idx_q;
  logic             cmp_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_length <= '0;
      hash_sum    <= '0;
      too_long    <= 1'b0;
      clr_addr    <= '0;
    end else begin
      if (cmd.clr_adv) clr_addr <= clr_addr + 1'b1;
      if (cmd.word_reset) begin
        word_length <= '0;
        hash_sum    <= '0;
        too_long    <= 1'b0;
      end else if (cmd.letter_in) begin
        if (word_length < LEN_W'(WORD_MAX)) begin
          word_buffer[POS_W'(word_length)] <= letter;
          hash_sum    <= hash_sum + HASH_W'(prod);
          word_length <= word_length + 1'b1;
        end else begin
          too_long <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_walk) begin
      key    <= hash_mod;
      start  <= hash_mod;
      probes <= CNT_W'(1);
      j      <= '0;
    end
    if (cmd.step) begin
      key    <= key_next;
      j      <= j1;
      probes <= probes + 1'b1;
    end
    if (cmd.cmp_start || cmd.start_walk) begin
      idx      <= '0;
      mismatch <= 1'b0;
      cmp_valid <= 1'b0;
    end else if (cmd.cmp_adv) begin
      cmp_valid <= 1'b1;
      idx_q     <= idx;
      if (cmp_valid && ltr_rd != word_buffer[idx_q]) mismatch <= 1'b1;
      if (LEN_W'(idx) + 1'b1 < word_length) idx <= idx + 1'b1;
    end else if (cmd.write_adv) begin
      idx <= idx + 1'b1;
    end
  end

  // cmp_done when the last letter's read data has been checked
  assign sts.clr_done   = (clr_addr == SLOT_W'(TABLE_SIZE - 1));
  assign sts.len_empty  = (len_rd == '0);
  assign sts.len_eq     = (len_rd == word_length);
  assign sts.cmp_done   = cmp_valid && (LEN_W'(idx_q) + 1'b1 == word_length);
  assign sts.cmp_ok     = !mismatch && (ltr_rd == word_buffer[idx_q]);
  assign sts.walk_end   = (probes >= CNT_W'(TABLE_SIZE)) || (key_next == start);
  assign sts.write_done = (LEN_W'(idx) + 1'b1 >= word_length);
  assign sts.too_long   = too_long;
  assign slot_out   = 10'(key);
  assign probes_out = 10'(probes);
endmodule

// File: sv/whtdp_ctrl.sv
// Controller state machine and result register.
module whtdp_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_beat,
  input  logic            op,
  input  logic            last,
  input  whtdp_pkg::sts_t sts,
  input  logic [9:0]      slot_in,
  input  logic [9:0]      probes_in,
  output whtdp_pkg::cmd_t cmd,
  output logic            s_ready,
  output logic            m_valid,
  input  logic            m_ready,
  output logic [2:0]      status,
  output logic [9:0]      slot,
  output logic [9:0]      probes
);
  import whtdp_pkg::*;

  state_t state, state_next;
  logic   op_q;
  logic   res_load;
  logic [2:0] res_status;
  logic       res_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      m_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (res_load) m_valid <= 1'b1;
      else if (m_ready) m_valid <= 1'b0;
    end
    if (in_beat && last) op_q <= op;
    if (res_load) begin
      status <= res_status;
      slot   <= res_zero ? '0 : slot_in;
      probes <= (res_status == ST_TOO_LONG) ? '0 : probes_in;
    end
  end

  assign s_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    res_load   = 1'b0;
    res_status = ST_INSERTED;
    res_zero   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear   = 1'b1;
        cmd.clr_adv = 1'b1;
        if (sts.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_beat) begin
          cmd.letter_in = 1'b1;
          if (last) state_next = S_DONE;
        end
      end
      S_DONE: begin
        // hold the word until the previous result has left
        if (!m_valid) begin
          if (sts.too_long) begin
            res_load   = 1'b1;
            res_status = ST_TOO_LONG;
            res_zero   = 1'b1;
            cmd.word_reset = 1'b1;
            state_next = S_IDLE;
          end else begin
            cmd.start_walk = 1'b1;
            state_next = S_READ;
          end
        end
      end
      S_READ: begin
        cmd.cmp_start = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (!op_q) begin
          if (sts.len_empty) begin
            cmd.cmp_start = 1'b1;
            state_next = S_WRITE;
          end else state_next = S_STEP;
        end else if (sts.len_eq) begin
          cmd.cmp_adv = 1'b1;
          state_next = S_CMP;
        end else state_next = S_STEP;
      end
      S_CMP: begin
        if (sts.cmp_done) begin
          if (sts.cmp_ok) begin
            res_load   = 1'b1;
            res_status = ST_FOUND;
            cmd.word_reset = 1'b1;
            state_next = S_IDLE;
          end else state_next = S_STEP;
        end else cmd.cmp_adv = 1'b1;
      end
      S_STEP: begin
        if (sts.walk_end) begin
          res_load   = 1'b1;
          res_status = op_q ? ST_NOT_FOUND : ST_FULL;
          res_zero   = 1'b1;
          cmd.word_reset = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.step = 1'b1;
          state_next = S_READ;
        end
      end
      S_WRITE: begin
        cmd.write_adv = 1'b1;
        if (sts.write_done) begin
          res_load   = 1'b1;
          res_status = ST_INSERTED;
          cmd.word_reset = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

// File: sv/word_hash_table_double_probe.sv
// Top level of the double-probe word hash table.
// Letters enter one per beat while idle, also while a result beat waits; after a word's
// final letter, once no result is waiting, a probe walk starts over the table, each slot
// passing the read, check and step states, with a letter-by-letter compare on a lookup
// of a slot of equal length, and an insert writes one letter per cycle. A result is one beat.
// After reset a clearing pass empties the length table before any letter is taken.
module word_hash_table_double_probe (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [4:0] letter
  input  logic        s_tlast,
  input  logic        s_tuser,   // op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // [2:0] status, [12:3] slot, [22:13] probes
);
  import whtdp_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic [9:0] slot_i, probes_i, slot_o, probes_o;
  logic [2:0] status_o;
  logic in_beat;

  assign in_beat = s_tvalid && s_tready;

  whtdp_datapath u_dp (
    .clk, .rst, .cmd, .letter(s_tdata[4:0]), .sts,
    .slot_out(slot_i), .probes_out(probes_i));

  whtdp_ctrl u_ctrl (
    .clk, .rst, .in_beat, .op(s_tuser), .last(s_tlast), .sts,
    .slot_in(slot_i), .probes_in(probes_i), .cmd,
    .s_ready(s_tready), .m_valid(m_tvalid), .m_ready(m_tready),
    .status(status_o), .slot(slot_o), .probes(probes_o));

  assign m_tdata = {1'b0, probes_o, slot_o, status_o};
endmodule

// File: sv/whtdp_checker.sv
// Port-level checks for the word hash table, bound to the top level.
module whtdp_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);
  import whtdp_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[2:0] <= ST_TOO_LONG) else $error("bad status");
  a_fail_slot: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[2:0] == ST_FULL || m_tdata[2:0] == ST_NOT_FOUND ||
                 m_tdata[2:0] == ST_TOO_LONG)
    |-> m_tdata[12:3] == 10'd0) else $error("slot on failure");
  a_probes: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2:0] != ST_TOO_LONG |-> m_tdata[22:13] != 10'd0)
    else $error("no probe");
  a_gap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready |=> !m_tvalid) else $error("result beats back to back");
endmodule

bind word_hash_table_double_probe whtdp_checker u_chk (
  .clk, .rst, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata);

// File: tb/sv/word_hash_table_double_probe_tb.sv
// Testbench for the double-probe word hash table: directed and random words checked beat by beat.
module word_hash_table_double_probe_tb;
  import whtdp_pkg::*;

  typedef struct packed {
    logic [9:0] probes;
    logic [9:0] slot;
    logic [2:0] status;
  } verdict_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;

  word_hash_table_double_probe DUT (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow table
  logic [4:0]  tbl_ltr [TABLE_SIZE][WORD_MAX];
  logic [5:0]  tbl_len [TABLE_SIZE];
  logic [4:0]  cur_word [WORD_MAX];
  int          cur_len;
  int          cur_hash;
  bit          cur_long;
  verdict_t    pending_q [$];
  int          errors;
  int          results_seen;
  int          words_sent;
  bit          rx_idle_en = 1'b1;
  bit          tx_idle_en = 1'b1;
  int          rx_hold;
  int          quiet_cycles;

  // stored words, so lookups can hit
  typedef struct {
    logic [4:0] l [WORD_MAX];
    int         n;
  } word_t;
  word_t known_q [$];

  function automatic bit slot_hit(int s);
    if (tbl_len[s] != cur_len) return 1'b0;
    for (int i = 0; i < cur_len; i++)
      if (tbl_ltr[s][i] != cur_word[i]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic predict_letter(logic [4:0] ltr, bit fin, bit lookup);
    verdict_t v;
    int home, key, j, cnt;
    bit ok;
    if (cur_len < WORD_MAX) begin
      cur_word[cur_len] = ltr;
      cur_hash = (cur_hash + ltr * 26 * cur_len) % TABLE_SIZE;
      cur_len++;
    end else begin
      cur_long = 1'b1;
    end
    if (!fin) return;
    v = '0;
    if (cur_long) begin
      v.status = ST_TOO_LONG;
    end else begin
      home = cur_hash;
      key = home;
      j = 0;
      cnt = 1;
      ok = 1'b0;
      forever begin
        if (lookup ? slot_hit(key) : (tbl_len[key] == 0)) begin
          ok = 1'b1;
          break;
        end
        if (cnt >= TABLE_SIZE) break;
        j++;
        key = (key + j * (1 + key % (TABLE_SIZE - 1))) % TABLE_SIZE;
        if (key == home) break;
        cnt++;
      end
      v.probes = 10'(cnt);
      if (!lookup) begin
        if (ok) begin
          for (int i = 0; i < cur_len; i++) tbl_ltr[key][i] = cur_word[i];
          tbl_len[key] = 6'(cur_len);
          v.status = ST_INSERTED;
          v.slot = 10'(key);
        end else begin
          v.status = ST_FULL;
        end
      end else begin
        v.status = ok ? ST_FOUND : ST_NOT_FOUND;
        if (ok) v.slot = 10'(key);
      end
    end
    pending_q.push_back(v);
    cur_len = 0;
    cur_hash = 0;
    cur_long = 1'b0;
  endtask

  // called at a falling edge; returns at the falling edge after the beat, still valid
  task automatic send_letter(logic [4:0] ltr, bit fin, bit lookup);
    int gap;
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 6);
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, ltr};
    s_tlast  <= fin;
    s_tuser  <= fin ? lookup : 1'($urandom_range(0, 1));
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_letter(ltr, fin, lookup);
    @(negedge clk);
  endtask

  task automatic send_word(word_t w, bit lookup);
    for (int i = 0; i < w.n; i++)
      send_letter(w.l[i], i == w.n - 1, lookup);
    words_sent++;
  endtask

  function automatic word_t rand_word(int maxn);
    word_t w;
    w.n = $urandom_range(1, maxn);
    for (int i = 0; i < WORD_MAX; i++) w.l[i] = 5'($urandom_range(0, 25));
    return w;
  endfunction

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    verdict_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[22:0];
      results_seen++;
      if (pending_q.size() == 0) begin
        $error("unexpected result beat %h", m_tdata);
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (got.status !== want.status) begin
          $error("status exp %0d got %0d", want.status, got.status);
          errors++;
        end
        if (got.slot !== want.slot) begin
          $error("slot exp %0d got %0d", want.slot, got.slot);
          errors++;
        end
        if (got.probes !== want.probes) begin
          $error("probes exp %0d got %0d", want.probes, got.probes);
          errors++;
        end
      end
    end
  end

  // receiver backpressure
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      m_tready <= 1'b0;
      rx_hold--;
    end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
      m_tready <= 1'b0;
      rx_hold = $urandom_range(0, 5);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // watchdog: the reset clear pass and the longest walk fit well inside this
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 60000) begin
      $display("word_hash_table_double_probe_tb: FAIL");
      $finish;
    end
  end

  task automatic test_extremes();
    word_t w;
    w.n = 1;
    for (int i = 0; i < WORD_MAX; i++) w.l[i] = 5'd0;
    send_word(w, 1'b1);                 // lookup in empty table
    send_word(w, 1'b0);
    send_word(w, 1'b0);                 // duplicate
    send_word(w, 1'b1);
    w.n = WORD_MAX;
    for (int i = 0; i < WORD_MAX; i++) w.l[i] = 5'd25;
    send_word(w, 1'b0);
    send_word(w, 1'b1);
    for (int i = 0; i < WORD_MAX; i++) w.l[i] = 5'd31;  // letters above 25
    send_word(w, 1'b0);
    send_word(w, 1'b1);
    w.l[0] = 5'd10;
    w.l[1] = 5'd21;
    w.n = 2;
    send_word(w, 1'b0);
    send_word(w, 1'b1);
    known_q.push_back(w);
  endtask

  task automatic test_too_long();
    word_t w;
    w = rand_word(WORD_MAX);
    w.n = WORD_MAX;
    for (int i = 0; i < WORD_MAX; i++) send_letter(w.l[i], 1'b0, 1'b0);
    send_letter(5'd3, 1'b1, 1'b0);
    for (int i = 0; i < WORD_MAX + 3; i++) send_letter(5'd7, i == WORD_MAX + 2, 1'b1);
    words_sent += 2;
  endtask

  task automatic test_backpressure();
    word_t w;
    rx_hold = 300;
    for (int k = 0; k < 12; k++) begin
      w = rand_word(4);
      send_word(w, 1'b0);
      known_q.push_back(w);
    end
    drain();                            // sender waits for every result
  endtask

  task automatic test_random(int n_letters);
    word_t w;
    int sent;
    sent = 0;
    while (sent < n_letters) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          w = rand_word($urandom_range(0, 3) == 0 ? WORD_MAX : 5);
          send_word(w, 1'b0);
          known_q.push_back(w);
        end
        4, 5, 6, 7: begin
          if (known_q.size() != 0) w = known_q[$urandom_range(0, known_q.size() - 1)];
          else w = rand_word(5);
          send_word(w, 1'b1);
        end
        8: begin
          w = rand_word(5);
          for (int i = 0; i < w.n; i++) w.l[i] = 5'($urandom_range(0, 31));
          send_word(w, 1'($urandom_range(0, 1)));
        end
        default: begin
          w = rand_word(WORD_MAX);
          w.n = WORD_MAX;
          for (int i = 0; i < WORD_MAX; i++) send_letter(w.l[i], 1'b0, 1'b0);
          send_letter(5'($urandom_range(0, 31)), 1'b1, 1'($urandom_range(0, 1)));
          words_sent++;
          sent++;
        end
      endcase
      sent += w.n;
    end
  endtask

  // a small cluster of identical words exercises walks over occupied slots and a repeated-word lookup
  task automatic test_collisions();
    word_t w;
    w = rand_word(3);
    for (int k = 0; k < 10; k++) send_word(w, 1'b0);
    send_word(w, 1'b1);
    known_q.push_back(w);
  endtask

  initial begin
    errors = 0;
    results_seen = 0;
    words_sent = 0;
    rx_hold = 0;
    cur_len = 0;
    cur_hash = 0;
    cur_long = 1'b0;
    for (int s = 0; s < TABLE_SIZE; s++) tbl_len[s] = '0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    test_extremes();
    test_too_long();
    test_backpressure();
    test_collisions();
    test_random(370);
    rx_idle_en = 1'b0;
    tx_idle_en = 1'b0;
    test_random(100);
    drain();
    $display("Covered %0d words with %0d results: inserts, duplicates, lookups,",
             words_sent, results_seen);
    $display("overlong words, letters above 25, idle gaps and a long output stall.");
    if (errors == 0 && pending_q.size() == 0) begin
      $display("word_hash_table_double_probe_tb: PASS");
    end else begin
      $display("word_hash_table_double_probe_tb: FAIL");
    end
    $finish;
  end
endmodule

// File: files.f
sv/whtdp_pkg.sv
sv/whtdp_ram.sv
sv/whtdp_datapath.sv
sv/whtdp_ctrl.sv
sv/word_hash_table_double_probe.sv
sv/whtdp_checker.sv
tb/sv/word_hash_table_double_probe_tb.sv
